// File: rtl/mpid_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mpid_pkg
// Shared types and constants for the multichannel PID controller.
// ----------------------------------------------------------------------------
package mpid_pkg;

  localparam int VAL_W    = 24;  // Q16.8 sample values
  localparam int ERR_W    = 25;  // setpoint - measured
  localparam int GAIN_W   = 16;  // Q8.8 gains
  localparam int INTEG_W  = 40;  // integral accumulator
  localparam int HELD_W   = 24;  // held incremental drive
  localparam int DRIVE_W  = 19;  // clamped drive
  localparam int CH_W     = 2;   // channel field
  localparam int CFG_W    = 64;  // widest register
  localparam int CFG_IDX_W = 2;

  localparam int POS_LIMIT = 2560;    // 10.0 in Q16.8
  localparam int INC_LIMIT = 256000;  // 1000.0 in Q16.8

  localparam logic MODE_POSITIONAL  = 1'b0;
  localparam logic MODE_INCREMENTAL = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KP   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KI   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KD   = 2'd3;

  typedef struct packed {
    logic             mode;
    logic [CFG_W-1:0] kp;
    logic [CFG_W-1:0] ki;
    logic [CFG_W-1:0] kd;
  } cfg_t;

  typedef struct packed {
    logic signed [INTEG_W-1:0] integral;
    logic signed [ERR_W-1:0]   last_err;
    logic signed [ERR_W-1:0]   older_err;
    logic signed [HELD_W-1:0]  held;
  } chan_state_t;

endpackage : mpid_pkg
`default_nettype wire

// File: rtl/mpid_in_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mpid_in_if
// Sample channel: valid/ready handshake with channel, setpoint, measured.
// ----------------------------------------------------------------------------
interface mpid_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         channel;
  logic signed [23:0] setpoint;
  logic signed [23:0] measured;

  modport source (output valid, output channel, output setpoint, output measured,
                  input ready);
  modport sink   (input valid, input channel, input setpoint, input measured,
                  output ready);
endinterface : mpid_in_if
`default_nettype wire

// File: rtl/mpid_out_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mpid_out_if
// Result channel: valid/ready handshake with channel_out and drive.
// ----------------------------------------------------------------------------
interface mpid_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         channel_out;
  logic signed [18:0] drive;

  modport source (output valid, output channel_out, output drive, input ready);
  modport sink   (input valid, input channel_out, input drive, output ready);
endinterface : mpid_out_if
`default_nettype wire

// File: rtl/mpid_cfg_regs.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mpid_cfg_regs
// Mode and packed gain registers behind the plain write port.
// ----------------------------------------------------------------------------
module mpid_cfg_regs
  import mpid_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 wr_en,
  input  wire logic [CFG_IDX_W-1:0] wr_index,
  input  wire logic [CFG_W-1:0]     wr_data,
  output cfg_t                      cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (wr_en) begin
      case (wr_index)
        REG_MODE: cfg.mode <= wr_data[0];
        REG_KP:   cfg.kp   <= wr_data;
        REG_KI:   cfg.ki   <= wr_data;
        REG_KD:   cfg.kd   <= wr_data;
        default: begin
        end
      endcase
    end
  end

endmodule : mpid_cfg_regs
`default_nettype wire

// File: rtl/mpid_state.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mpid_state
// Per-channel controller state in flip-flops, one read and one write port.
// ----------------------------------------------------------------------------
module mpid_state
  import mpid_pkg::*;
#(
  parameter int CHANNELS = 4
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic [CH_W-1:0]            rd_channel,
  output chan_state_t                     rd_entry,
  input  wire logic                       wr_en,
  input  wire logic [CH_W-1:0]            wr_channel,
  input  wire chan_state_t                wr_entry
);

  localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  chan_state_t bank [CHANNELS];

  // out-of-range channels are filtered upstream, never written or used
  assign rd_entry = bank[rd_channel[IDX_W-1:0]];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CHANNELS; i++) begin
        bank[i] <= '0;
      end
    end else if (wr_en) begin
      bank[wr_channel[IDX_W-1:0]] <= wr_entry;
    end
  end

endmodule : mpid_state
`default_nettype wire

// File: rtl/mpid_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mpid_core
// Error terms, three shared gain multipliers, scaling and clamping for both
// PID forms, plus the next per-channel state.
// ----------------------------------------------------------------------------
module mpid_core
  import mpid_pkg::*;
(
  input  wire cfg_t                 cfg,
  input  wire logic                 chan_ok,
  input  wire logic [CH_W-1:0]      channel,
  input  wire logic signed [VAL_W-1:0] setpoint,
  input  wire logic signed [VAL_W-1:0] measured,
  input  wire chan_state_t          cur,
  output logic signed [DRIVE_W-1:0] drive,
  output chan_state_t               nxt
);

  localparam int D1_W  = ERR_W + 1;
  localparam int D2_W  = ERR_W + 2;
  localparam int SUM_W = INTEG_W + 1;
  localparam int PP_W  = GAIN_W + D1_W;
  localparam int PI_W  = GAIN_W + INTEG_W;
  localparam int PD_W  = GAIN_W + D2_W;
  localparam int ACC_W = PI_W + 2;
  localparam int SH_W  = ACC_W - 8;
  localparam int INC_W = SH_W + 1;

  localparam logic signed [SUM_W-1:0] INT_HI = SUM_W'((64'sd1 <<< (INTEG_W - 1)) - 1);
  localparam logic signed [SUM_W-1:0] INT_LO = SUM_W'(-(64'sd1 <<< (INTEG_W - 1)));
  localparam logic signed [SH_W-1:0]  POS_HI = SH_W'(POS_LIMIT);
  localparam logic signed [SH_W-1:0]  POS_LO = SH_W'(-POS_LIMIT);
  localparam logic signed [INC_W-1:0] INC_HI = INC_W'(INC_LIMIT);
  localparam logic signed [INC_W-1:0] INC_LO = INC_W'(-INC_LIMIT);

  logic signed [ERR_W-1:0]   err;
  logic signed [D1_W-1:0]    d1;
  logic signed [D2_W-1:0]    d2;
  logic signed [SUM_W-1:0]   sum_raw;
  logic signed [INTEG_W-1:0] sum_sat;
  logic signed [GAIN_W-1:0]  kp, ki, kd;
  logic signed [D1_W-1:0]    op_p;
  logic signed [INTEG_W-1:0] op_i;
  logic signed [D2_W-1:0]    op_d;
  logic signed [PP_W-1:0]    prod_p;
  logic signed [PI_W-1:0]    prod_i;
  logic signed [PD_W-1:0]    prod_d;
  logic signed [ACC_W-1:0]   acc;
  logic signed [SH_W-1:0]    scaled;
  logic signed [INC_W-1:0]   inc_sum;
  logic signed [DRIVE_W-1:0] pos_drive, inc_drive;

  always_comb begin
    err = ERR_W'(setpoint) - ERR_W'(measured);
    d1  = D1_W'(err) - D1_W'(cur.last_err);
    // e - 2*e1 + e2
    d2  = D2_W'(err) - (D2_W'(cur.last_err) <<< 1) + D2_W'(cur.older_err);

    sum_raw = SUM_W'(cur.integral) + SUM_W'(err);
    if (sum_raw > INT_HI) begin
      sum_sat = INTEG_W'(INT_HI);
    end else if (sum_raw < INT_LO) begin
      sum_sat = INTEG_W'(INT_LO);
    end else begin
      sum_sat = INTEG_W'(sum_raw);
    end

    kp = cfg.kp[GAIN_W*channel +: GAIN_W];
    ki = cfg.ki[GAIN_W*channel +: GAIN_W];
    kd = cfg.kd[GAIN_W*channel +: GAIN_W];

    // operand selection shares the three multipliers between the two forms
    if (cfg.mode == MODE_POSITIONAL) begin
      op_p = D1_W'(err);
      op_i = sum_sat;
      op_d = D2_W'(d1);
    end else begin
      op_p = d1;
      op_i = INTEG_W'(err);
      op_d = d2;
    end

    prod_p = PP_W'(kp) * PP_W'(op_p);
    prod_i = PI_W'(ki) * PI_W'(op_i);
    prod_d = PD_W'(kd) * PD_W'(op_d);
    acc    = ACC_W'(prod_p) + ACC_W'(prod_i) + ACC_W'(prod_d);
    // arithmetic shift floors toward minus infinity
    scaled = acc[ACC_W-1:8];

    if (scaled > POS_HI) begin
      pos_drive = DRIVE_W'(POS_HI);
    end else if (scaled < POS_LO) begin
      pos_drive = DRIVE_W'(POS_LO);
    end else begin
      pos_drive = DRIVE_W'(scaled);
    end

    inc_sum = INC_W'(cur.held) + INC_W'(scaled);
    if (inc_sum > INC_HI) begin
      inc_drive = DRIVE_W'(INC_HI);
    end else if (inc_sum < INC_LO) begin
      inc_drive = DRIVE_W'(INC_LO);
    end else begin
      inc_drive = DRIVE_W'(inc_sum);
    end

    nxt = cur;
    nxt.last_err = err;
    if (cfg.mode == MODE_POSITIONAL) begin
      nxt.integral = sum_sat;
      drive        = pos_drive;
    end else begin
      nxt.older_err = cur.last_err;
      nxt.held      = HELD_W'(inc_drive);
      drive         = inc_drive;
    end

    if (!chan_ok) begin
      drive = '0;
    end
  end

endmodule : mpid_core
`default_nettype wire

// File: rtl/multichannel_pid_controller.sv
`default_nettype none
// ----------------------------------------------------------------------------
// multichannel_pid_controller
// Per-channel PID regulator, positional or incremental form.
// ----------------------------------------------------------------------------
// Accepts one sample per clock and returns one drive value per sample, in
// order. A sample is captured in an input register; from there the error terms,
// the three gain products, scaling and clamp are computed in one pass, and the
// result register is loaded once it is free while that channel's state is
// written, so a following sample on the same channel already sees the update.
// Throughput is one sample per cycle, as the gain multipliers lie on one
// combinational path; it drops only while the result side holds ready low.
// Samples for a channel at or above CHANNELS return drive zero and leave all
// state untouched. Write the mode and gain registers only while no sample is
// in flight.
module multichannel_pid_controller
  import mpid_pkg::*;
#(
  parameter int CHANNELS = 4
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  mpid_in_if.sink                   sample,
  mpid_out_if.source                result,
  input  wire logic                 wr_en,
  input  wire logic [CFG_IDX_W-1:0] wr_index,
  input  wire logic [CFG_W-1:0]     wr_data
);

  cfg_t        cfg;
  chan_state_t cur_entry;
  chan_state_t nxt_entry;

  logic                      s1_valid;
  logic [CH_W-1:0]           s1_channel;
  logic signed [VAL_W-1:0]   s1_setpoint;
  logic signed [VAL_W-1:0]   s1_measured;
  logic                      out_valid;
  logic [CH_W-1:0]           out_channel;
  logic signed [DRIVE_W-1:0] out_drive;
  logic signed [DRIVE_W-1:0] core_drive;
  logic                      chan_ok;
  logic                      out_free;
  logic                      advance;

  assign chan_ok  = (32'(s1_channel) < CHANNELS);
  assign out_free = !out_valid || result.ready;
  assign advance  = s1_valid && out_free;

  assign sample.ready       = !s1_valid || advance;
  assign result.valid       = out_valid;
  assign result.channel_out = out_channel;
  assign result.drive       = out_drive;

  mpid_cfg_regs u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .cfg      (cfg)
  );

  mpid_state #(.CHANNELS(CHANNELS)) u_state (
    .clk        (clk),
    .rst        (rst),
    .rd_channel (s1_channel),
    .rd_entry   (cur_entry),
    .wr_en      (advance && chan_ok),
    .wr_channel (s1_channel),
    .wr_entry   (nxt_entry)
  );

  mpid_core u_core (
    .cfg      (cfg),
    .chan_ok  (chan_ok),
    .channel  (s1_channel),
    .setpoint (s1_setpoint),
    .measured (s1_measured),
    .cur      (cur_entry),
    .drive    (core_drive),
    .nxt      (nxt_entry)
  );

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (sample.ready) begin
      s1_valid <= sample.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (sample.valid && sample.ready) begin
      s1_channel  <= sample.channel;
      s1_setpoint <= sample.setpoint;
      s1_measured <= sample.measured;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_channel <= s1_channel;
      out_drive   <= core_drive;
    end
  end

  a_drive_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_drive <= 19'sd256000) && (out_drive >= -19'sd256000))
    else $error("drive outside incremental clamp range");

  a_bad_channel_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (32'(out_channel) >= CHANNELS) |-> out_drive == '0)
    else $error("nonzero drive for unsupported channel");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !sample.ready |-> s1_valid && out_valid && !result.ready)
    else $error("input stalled without a blocked result");

  a_held_sample: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !out_free |=> s1_valid && $stable(s1_channel) && $stable(s1_setpoint))
    else $error("stalled sample lost from input register");

endmodule : multichannel_pid_controller
`default_nettype wire
